[sv/wpm_pkg.sv]
package wpm_pkg;

    // default pattern capacity in bytes
    localparam int MAX_PATTERN = 32;

    localparam logic [7:0] STAR_BYTE  = 8'h2A;
    localparam logic [7:0] QMARK_BYTE = 8'h3F;

    typedef enum logic [1:0] {
        MODE_CLEAR  = 2'd0,
        MODE_APPEND = 2'd1,
        MODE_NAME   = 2'd2,
        MODE_FINISH = 2'd3
    } mode_t;

    typedef struct packed {
        mode_t      mode;
        logic [7:0] symbol;
    } item_t;

    typedef struct packed {
        logic matched;
        logic pattern_overflow;
    } result_t;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic       clear;
        logic       append;
        logic       name;
        logic       finish;
        logic [7:0] symbol;
    } ctl_t;

    // what a cell hands to its right-hand neighbour
    typedef struct packed {
        logic vld;
        logic init;
        logic cur;
        logic row_next;
    } link_t;

endpackage

[sv/wpm_cell.sv]
module wpm_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  wpm_pkg::ctl_t  ctl,
    input  wpm_pkg::link_t left,
    output wpm_pkg::link_t right
);

    logic       vld_reg, vld_next;
    logic       init_reg, init_next;
    logic       cur_reg, cur_next;
    logic [7:0] sym_reg;
    logic       is_new;
    logic       is_star;
    logic       row_next;

    // this cell takes the appended byte when it is the first free one
    assign is_new  = ctl.append & left.vld & ~vld_reg;
    assign is_star = (sym_reg == wpm_pkg::STAR_BYTE);

    always_comb
    begin
        if (!vld_reg)
        begin
            row_next = 1'b0;
        end
        else if (is_star)
        begin
            row_next = left.row_next | cur_reg;
        end
        else if ((sym_reg == wpm_pkg::QMARK_BYTE) || (sym_reg == ctl.symbol))
        begin
            row_next = left.cur;
        end
        else
        begin
            row_next = 1'b0;
        end
    end

    always_comb
    begin
        vld_next  = vld_reg;
        init_next = init_reg;
        cur_next  = cur_reg;
        if (ctl.clear)
        begin
            vld_next  = 1'b0;
            init_next = 1'b0;
            cur_next  = 1'b0;
        end
        else if (ctl.append)
        begin
            if (is_new)
            begin
                vld_next  = 1'b1;
                init_next = (ctl.symbol == wpm_pkg::STAR_BYTE) ? left.init : 1'b0;
            end
            cur_next = init_next;
        end
        else if (ctl.name)
        begin
            cur_next = row_next;
        end
        else if (ctl.finish)
        begin
            cur_next = init_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= 1'b0;
            init_reg <= 1'b0;
            cur_reg  <= 1'b0;
        end
        else
        begin
            vld_reg  <= vld_next;
            init_reg <= init_next;
            cur_reg  <= cur_next;
        end
    end

    // pattern byte, meaningful only while valid
    always_ff @(posedge clk)
    begin
        if (is_new)
        begin
            sym_reg <= ctl.symbol;
        end
    end

    assign right.vld      = vld_reg;
    assign right.init     = init_reg;
    assign right.cur      = cur_reg;
    assign right.row_next = row_next;

endmodule

[sv/wildcard_pattern_match.sv]
// Glob matcher over a streamed name. Load a pattern with a clear item followed
// by one append item per byte ('*' matches any run of bytes, '?' exactly one
// byte), then stream the name one byte per name item and close it with a
// finish item, which returns one result (matched, pattern_overflow) and
// rearms the matcher for the next name. An item is taken whenever it is valid
// and not stalled, and items may follow back to back; the name update runs
// combinationally through a row of MAX_PATTERN cells, with the star cells
// passing a match along an OR ripple whose length is the pattern length, and
// that ripple sets the clock limit. Results leave through one output register;
// the input stalls only while that register holds a result that is itself
// stalled. Bytes appended beyond MAX_PATTERN are dropped and flagged until the
// next clear. An empty pattern matches only an empty name.
module wildcard_pattern_match #(
    parameter int MAX_PATTERN = wpm_pkg::MAX_PATTERN
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  wpm_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output wpm_pkg::result_t result
);

    // accepted item decode
    logic          accept;
    wpm_pkg::ctl_t ctl;

    // cell chain: links[0] is the fixed empty-pattern column
    wpm_pkg::link_t links [0:MAX_PATTERN];
    logic [MAX_PATTERN-1:0] vld_vec;
    logic [MAX_PATTERN-1:0] hit_vec;

    // column zero: its initial bit is always set
    logic cur0_reg, cur0_next;

    // overflow since last clear
    logic ovf_reg, ovf_next;

    // result register
    logic             res_valid_reg, res_valid_next;
    wpm_pkg::result_t res_reg, res_next;
    logic             verdict;

    assign item_stall = res_valid_reg & result_stall;
    assign accept     = item_valid & ~item_stall;

    always_comb
    begin
        ctl.clear  = 1'b0;
        ctl.append = 1'b0;
        ctl.name   = 1'b0;
        ctl.finish = 1'b0;
        ctl.symbol = item.symbol;
        if (accept)
        begin
            unique case (item.mode)
                wpm_pkg::MODE_CLEAR:  ctl.clear  = 1'b1;
                wpm_pkg::MODE_APPEND: ctl.append = 1'b1;
                wpm_pkg::MODE_NAME:   ctl.name   = 1'b1;
                wpm_pkg::MODE_FINISH: ctl.finish = 1'b1;
                default:              ctl.clear  = 1'b0;
            endcase
        end
    end

    // the empty prefix of the pattern: matches only before any name byte
    assign links[0].vld      = 1'b1;
    assign links[0].init     = 1'b1;
    assign links[0].cur      = cur0_reg;
    assign links[0].row_next = 1'b0;

    genvar g;
    generate
        for (g = 0; g < MAX_PATTERN; g++)
        begin : g_cell
            wpm_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .ctl   (ctl),
                .left  (links[g]),
                .right (links[g+1])
            );

            assign vld_vec[g] = links[g+1].vld;

            // the last filled cell holds the whole-pattern column
            if (g == MAX_PATTERN - 1)
            begin : g_tail
                assign hit_vec[g] = links[g+1].vld & links[g+1].cur;
            end
            else
            begin : g_body
                assign hit_vec[g] = links[g+1].vld & ~links[g+2].vld & links[g+1].cur;
            end
        end
    endgenerate

    // empty pattern falls back on column zero
    assign verdict = vld_vec[0] ? (|hit_vec) : cur0_reg;

    always_comb
    begin
        cur0_next = cur0_reg;
        ovf_next  = ovf_reg;
        if (ctl.clear)
        begin
            cur0_next = 1'b1;
            ovf_next  = 1'b0;
        end
        else if (ctl.append)
        begin
            cur0_next = 1'b1;
            if (vld_vec[MAX_PATTERN-1])
            begin
                ovf_next = 1'b1;
            end
        end
        else if (ctl.name)
        begin
            cur0_next = 1'b0;
        end
        else if (ctl.finish)
        begin
            cur0_next = 1'b1;
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg & result_stall;
        res_next       = res_reg;
        if (ctl.finish)
        begin
            res_valid_next            = 1'b1;
            res_next.matched          = verdict;
            res_next.pattern_overflow = ovf_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur0_reg      <= 1'b1;
            ovf_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            cur0_reg      <= cur0_next;
            ovf_reg       <= ovf_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    // filled cells always form a prefix of the row
    a_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        ((vld_vec + MAX_PATTERN'(1)) & vld_vec) == '0)
        else $error("pattern cells not filled as a prefix");

    // a clear empties the row and rearms column zero
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.clear |=> (vld_vec == '0) && cur0_reg && !ovf_reg)
        else $error("clear did not reset the pattern row");

    // a finish always leaves a result waiting
    a_finish: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.finish |=> res_valid_reg)
        else $error("finish item produced no result");

    // overflow only rises on an append into a full row
    a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ovf_reg) |-> $past(ctl.append) && $past(vld_vec[MAX_PATTERN-1]))
        else $error("overflow flagged without a dropped byte");

endmodule

[dv/testbench.sv]
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // predicts the verdict of each finish item and checks the result stream against it
    class match_scoreboard;
        logic [7:0]                    pat_bytes [wpm_pkg::MAX_PATTERN];
        int unsigned                   pat_len;
        logic [wpm_pkg::MAX_PATTERN:0] start_row;
        logic [wpm_pkg::MAX_PATTERN:0] live_row;
        logic                          dropped;
        wpm_pkg::result_t              verdicts [$];
        int unsigned                   mismatches;
        int unsigned                   verdicts_checked;
        int unsigned                   hits;
        int unsigned                   overflow_seen;

        function new();
            pat_len          = 0;
            dropped          = 1'b0;
            start_row        = {{wpm_pkg::MAX_PATTERN{1'b0}}, 1'b1};
            live_row         = start_row;
            mismatches       = 0;
            verdicts_checked = 0;
            hits             = 0;
            overflow_seen    = 0;
        endfunction

        // one name byte moves every cell of the row at once; star cells ripple left to right
        function void advance_row(logic [7:0] ch);
            logic [wpm_pkg::MAX_PATTERN:0] next_row;
            int                            j;
            next_row = '0;
            for (j = 1; j <= int'(pat_len); j++)
            begin
                if (pat_bytes[j-1] == wpm_pkg::STAR_BYTE)
                    next_row[j] = next_row[j-1] | live_row[j];
                else if (pat_bytes[j-1] == wpm_pkg::QMARK_BYTE || pat_bytes[j-1] == ch)
                    next_row[j] = live_row[j-1];
            end
            live_row = next_row;
        endfunction

        function void note_item(wpm_pkg::item_t it);
            wpm_pkg::result_t due;
            case (it.mode)
                wpm_pkg::MODE_CLEAR:
                begin
                    pat_len   = 0;
                    dropped   = 1'b0;
                    start_row = {{wpm_pkg::MAX_PATTERN{1'b0}}, 1'b1};
                    live_row  = start_row;
                end
                wpm_pkg::MODE_APPEND:
                begin
                    if (pat_len < wpm_pkg::MAX_PATTERN)
                    begin
                        pat_bytes[pat_len] = it.symbol;
                        pat_len++;
                        start_row[pat_len] = (it.symbol == wpm_pkg::STAR_BYTE) ?
                                             start_row[pat_len-1] : 1'b0;
                    end
                    else
                        dropped = 1'b1;
                    // a partial name is thrown away
                    live_row = start_row;
                end
                wpm_pkg::MODE_NAME:
                    advance_row(it.symbol);
                wpm_pkg::MODE_FINISH:
                begin
                    due.matched          = live_row[pat_len];
                    due.pattern_overflow = dropped;
                    verdicts.insert(verdicts.size(), due);
                    live_row = start_row;
                end
            endcase
        endfunction

        function void flag(string what, wpm_pkg::result_t due, wpm_pkg::result_t got);
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] %s: expected matched=%b overflow=%b, got matched=%b overflow=%b",
                         $time, what, due.matched, due.pattern_overflow,
                         got.matched, got.pattern_overflow);
        endfunction

        function void check_result(wpm_pkg::result_t got);
            wpm_pkg::result_t due;
            if (verdicts.size() == 0)
            begin
                flag("verdict with nothing outstanding", got, got);
                return;
            end
            due = verdicts.pop_front();
            verdicts_checked++;
            if (got.matched !== due.matched || got.pattern_overflow !== due.pattern_overflow)
                flag("verdict mismatch", due, got);
            if (due.matched)
                hits++;
            if (due.pattern_overflow)
                overflow_seen++;
        endfunction
    endclass

    logic             clk;
    logic             rst_n        = 1'b0;
    logic             item_valid   = 1'b0;
    logic             item_stall;
    wpm_pkg::item_t   item_bus     = '0;
    logic             result_valid;
    logic             result_stall = 1'b0;
    wpm_pkg::result_t result_bus;

    match_scoreboard sb;

    // sender and receiver idling, in percent
    int unsigned send_idle_pct  = 22;
    int unsigned recv_stall_pct = 79;

    // long receiver hold-off, requested by the stimulus and counted by the receiver
    int unsigned hold_token = 0;
    int unsigned hold_seen  = 0;
    int unsigned hold_left  = 0;

    int unsigned items_sent  = 0;
    int unsigned held_cycles = 0;

    // current pattern and the name being built from it
    logic [7:0] pat_q [$];
    logic [7:0] name_q [$];

    wildcard_pattern_match dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item_bus),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result_bus)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // receiver: a long hold-off takes priority over random stalling
    always @(posedge clk)
    begin
        if (hold_token != hold_seen)
        begin
            hold_seen    <= hold_token;
            hold_left    <= 64;
            result_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left    <= hold_left - 1;
            result_stall <= 1'b1;
        end
        else
            result_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // monitor: results are checked before the item of the same edge is noted,
    // since the output is registered and cannot belong to that item
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
                sb.check_result(result_bus);
            if (item_valid && !item_stall)
                sb.note_item(item_bus);
            if (item_valid && item_stall)
                held_cycles++;
        end
    end

    // offer one item, idling first at random, and return once it is taken;
    // valid stays high so that a following item goes out without a gap
    task automatic drive_item(wpm_pkg::mode_t m, logic [7:0] s);
        wpm_pkg::item_t it;
        it.mode   = m;
        it.symbol = s;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item_bus   <= it;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        items_sent++;
    endtask

    // stop offering and wait until every verdict has come back
    task automatic wait_drain();
        item_valid <= 1'b0;
        @(posedge clk);
        while (sb.verdicts.size() != 0)
            @(posedge clk);
    endtask

    // mostly a small alphabet so that names match often
    function automatic logic [7:0] filler_byte();
        if ($urandom_range(9) == 0)
            return 8'($urandom_range(255));
        return 8'h61 + 8'($urandom_range(2));
    endfunction

    function automatic logic [7:0] pattern_byte();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 30)
            return wpm_pkg::STAR_BYTE;
        if (r < 50)
            return wpm_pkg::QMARK_BYTE;
        return filler_byte();
    endfunction

    task automatic new_pattern();
        int unsigned r;
        int unsigned len;
        logic [7:0]  c;
        r = $urandom_range(99);
        // mostly short patterns, a few near or past capacity
        if (r < 85)
            len = $urandom_range(8);
        else if (r < 95)
            len = $urandom_range(9, wpm_pkg::MAX_PATTERN - 1);
        else
            len = $urandom_range(wpm_pkg::MAX_PATTERN, wpm_pkg::MAX_PATTERN + 4);
        pat_q.delete();
        drive_item(wpm_pkg::MODE_CLEAR, 8'($urandom_range(255)));
        repeat (len)
        begin
            c = pattern_byte();
            pat_q.insert(pat_q.size(), c);
            drive_item(wpm_pkg::MODE_APPEND, c);
        end
    endtask

    // a name that fits the stored part of the pattern, sometimes spoilt by one edit
    task automatic build_name();
        int          i;
        int unsigned pos;
        name_q.delete();
        for (i = 0; i < pat_q.size() && i < wpm_pkg::MAX_PATTERN; i++)
        begin
            if (pat_q[i] == wpm_pkg::STAR_BYTE)
                repeat ($urandom_range(3))
                    name_q.insert(name_q.size(), filler_byte());
            else if (pat_q[i] == wpm_pkg::QMARK_BYTE)
                name_q.insert(name_q.size(), 8'($urandom_range(255)));
            else
                name_q.insert(name_q.size(), pat_q[i]);
        end
        if ($urandom_range(9) < 4)
        begin
            pos = $urandom_range(name_q.size());
            case ($urandom_range(2))
                0: name_q.insert(pos, filler_byte());
                1: if (name_q.size() != 0) name_q.delete(pos % name_q.size());
                default: if (name_q.size() != 0) name_q[pos % name_q.size()] = filler_byte();
            endcase
        end
    endtask

    // one well-formed run (optional new pattern, a few names) or a burst of noise
    task automatic one_sequence();
        int unsigned i;
        if ($urandom_range(99) >= 80)
        begin
            repeat ($urandom_range(1, 6))
                drive_item(wpm_pkg::mode_t'($urandom_range(3)), 8'($urandom_range(255)));
            return;
        end
        if ($urandom_range(9) != 0)
            new_pattern();
        repeat ($urandom_range(1, 4))
        begin
            build_name();
            for (i = 0; i < name_q.size(); i++)
            begin
                // now and then the pattern grows in the middle of a name
                if ($urandom_range(49) == 0)
                begin
                    pat_q.insert(pat_q.size(), wpm_pkg::STAR_BYTE);
                    drive_item(wpm_pkg::MODE_APPEND, wpm_pkg::STAR_BYTE);
                end
                drive_item(wpm_pkg::MODE_NAME, name_q[i]);
            end
            drive_item(wpm_pkg::MODE_FINISH, 8'($urandom_range(255)));
        end
    endtask

    task automatic random_phase(int unsigned send_pct, int unsigned recv_pct,
                                int unsigned upto);
        send_idle_pct  = send_pct;
        recv_stall_pct <= recv_pct;
        while (items_sent < upto)
            one_sequence();
    endtask

    initial
    begin
        sb = new();
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty pattern straight after reset: empty name matches, any other does not
        drive_item(wpm_pkg::MODE_FINISH, 8'hFF);
        drive_item(wpm_pkg::MODE_NAME, 8'h00);
        drive_item(wpm_pkg::MODE_FINISH, 8'h00);
        // lone star matches anything, including extreme bytes
        drive_item(wpm_pkg::MODE_CLEAR, 8'hFF);
        drive_item(wpm_pkg::MODE_APPEND, wpm_pkg::STAR_BYTE);
        drive_item(wpm_pkg::MODE_FINISH, 8'h00);
        drive_item(wpm_pkg::MODE_NAME, 8'hFF);
        drive_item(wpm_pkg::MODE_NAME, 8'h00);
        drive_item(wpm_pkg::MODE_FINISH, 8'hFF);
        // literal, question mark, literal
        drive_item(wpm_pkg::MODE_CLEAR, 8'h00);
        drive_item(wpm_pkg::MODE_APPEND, "a");
        drive_item(wpm_pkg::MODE_APPEND, wpm_pkg::QMARK_BYTE);
        drive_item(wpm_pkg::MODE_APPEND, "b");
        drive_item(wpm_pkg::MODE_NAME, "a");
        drive_item(wpm_pkg::MODE_NAME, 8'hFF);
        drive_item(wpm_pkg::MODE_NAME, "b");
        drive_item(wpm_pkg::MODE_FINISH, 8'h00);
        // append in the middle of a name restarts it against the longer pattern
        drive_item(wpm_pkg::MODE_NAME, "a");
        drive_item(wpm_pkg::MODE_APPEND, wpm_pkg::STAR_BYTE);
        drive_item(wpm_pkg::MODE_NAME, "a");
        drive_item(wpm_pkg::MODE_NAME, "x");
        drive_item(wpm_pkg::MODE_NAME, "b");
        drive_item(wpm_pkg::MODE_NAME, "z");
        drive_item(wpm_pkg::MODE_FINISH, 8'h00);
        // clear in the middle of a name leaves an empty pattern and empty name
        drive_item(wpm_pkg::MODE_NAME, "a");
        drive_item(wpm_pkg::MODE_CLEAR, 8'h55);
        drive_item(wpm_pkg::MODE_FINISH, 8'hAA);
        pat_q.delete();

        random_phase(22, 79, 320);
        wait_drain();
        random_phase(79, 22, 620);
        wait_drain();

        // receiver holds off while the sender keeps offering, so the block backs up
        send_idle_pct  = 0;
        recv_stall_pct <= 0;
        hold_token     <= hold_token + 1;
        drive_item(wpm_pkg::MODE_CLEAR, 8'h00);
        drive_item(wpm_pkg::MODE_APPEND, wpm_pkg::STAR_BYTE);
        pat_q.delete();
        pat_q.insert(0, wpm_pkg::STAR_BYTE);
        repeat (8)
        begin
            drive_item(wpm_pkg::MODE_NAME, filler_byte());
            drive_item(wpm_pkg::MODE_FINISH, 8'h00);
        end
        wait_drain();

        random_phase(0, 0, 870);
        wait_drain();
        repeat (8)
            @(posedge clk);

        $display("run covered %0d items and %0d verdicts (%0d matches, %0d with overflow)",
                 items_sent, sb.verdicts_checked, sb.hits, sb.overflow_seen);
        $display("input held back for %0d cycles, %0d mismatches",
                 held_cycles, sb.mismatches);
        if (sb.mismatches == 0 && sb.verdicts.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // hang guard, far beyond the slowest correct run
    initial
    begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
